### src/jvsl_pkg.sv
// ----------------------------------------------------------------------------
// jvsl_pkg
// shared constants, types and limit tables of the joint velocity smoothing
// limiter
// ----------------------------------------------------------------------------
package jvsl_pkg;

  localparam int JOINTS  = 7;
  localparam int IDX_W   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int VEL_W   = 16;
  localparam int ALPHA_W = 17;
  localparam int HOLD_W  = 12;
  localparam int PROD_W  = VEL_W + 1 + ALPHA_W + 1;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(328);
  localparam logic [ALPHA_W-1:0] ALPHA_MIN   = ALPHA_W'(7);
  localparam logic [ALPHA_W-1:0] ALPHA_MAX   = ALPHA_W'(65536);
  localparam logic [HOLD_W-1:0]  HOLD_RESET  = HOLD_W'(3000);

  // configuration register indexes
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_HOLD  = 1'b1;

  typedef logic signed [VEL_W-1:0] vel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_DONE
  } state_t;

  // velocity limit per joint, Q3.12
  function automatic vel_t vel_cap(input logic [2:0] j);
    vel_t v;
    unique case (j)
      3'd0, 3'd1, 3'd2, 3'd3: v = 16'sd10732;
      3'd5:                   v = 16'sd17121;
      default:                v = 16'sd21545;
    endcase
    return v;
  endfunction

  // acceleration limit per tick, Q3.12
  function automatic vel_t step_cap(input logic [2:0] j);
    vel_t v;
    unique case (j)
      3'd0, 3'd4: v = 16'sd61;
      3'd1:       v = 16'sd31;
      3'd2:       v = 16'sd41;
      3'd3:       v = 16'sd51;
      default:    v = 16'sd82;
    endcase
    return v;
  endfunction

endpackage

### src/joint_velocity_smoothing_limiter.sv
// ----------------------------------------------------------------------------
// joint_velocity_smoothing_limiter
// ema smoothing of joint velocity targets with per-joint slew and velocity
// clamps, startup hold after restart
// ----------------------------------------------------------------------------
// throughput: a new word is accepted while idle or as the finished one moves
//   into the output register; one hold word every cycle while the output is
//   not stalled; a filtered word passes the single multiply/clamp lane and
//   the one ram read port, which visit the joints one per cycle
// reset: synchronous, clears control, registers to their reset values, all
//   stored velocities read as zero, hold counter zero
// ----------------------------------------------------------------------------
module joint_velocity_smoothing_limiter (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [jvsl_pkg::ALPHA_W-1:0]    cfg_data,
  // input word
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [jvsl_pkg::VEL_W-1:0] target_j0,
  input  logic signed [jvsl_pkg::VEL_W-1:0] target_j1,
  input  logic signed [jvsl_pkg::VEL_W-1:0] target_j2,
  input  logic signed [jvsl_pkg::VEL_W-1:0] target_j3,
  input  logic signed [jvsl_pkg::VEL_W-1:0] target_j4,
  input  logic signed [jvsl_pkg::VEL_W-1:0] target_j5,
  input  logic signed [jvsl_pkg::VEL_W-1:0] target_j6,
  input  logic                            restart,
  // output word
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [jvsl_pkg::VEL_W-1:0] cmd_j0,
  output logic signed [jvsl_pkg::VEL_W-1:0] cmd_j1,
  output logic signed [jvsl_pkg::VEL_W-1:0] cmd_j2,
  output logic signed [jvsl_pkg::VEL_W-1:0] cmd_j3,
  output logic signed [jvsl_pkg::VEL_W-1:0] cmd_j4,
  output logic signed [jvsl_pkg::VEL_W-1:0] cmd_j5,
  output logic signed [jvsl_pkg::VEL_W-1:0] cmd_j6,
  output logic                            holding
);

  localparam int J   = jvsl_pkg::JOINTS;
  localparam int IW  = jvsl_pkg::IDX_W;
  localparam int VW  = jvsl_pkg::VEL_W;
  localparam int AW  = jvsl_pkg::ALPHA_W;
  localparam int HW  = jvsl_pkg::HOLD_W;
  localparam int PW  = jvsl_pkg::PROD_W;
  localparam int SW  = PW - 16;          // width of the floor-shifted step
  localparam logic [IW-1:0] LAST_IDX = IW'(J - 1);

  // configuration registers
  logic [AW-1:0] alpha;
  logic [HW-1:0] hold_ticks;

  // control
  jvsl_pkg::state_t state, state_next;
  logic [HW-1:0]    hold_count;
  logic [J-1:0]     vbit;            // entry written since the last restart
  logic             hold_flag;

  // input word buffer
  jvsl_pkg::vel_t in_tgt [J];
  jvsl_pkg::vel_t tgt    [J];

  // read issue
  logic [IW-1:0] rd_idx;
  logic          rd_en;
  logic          rd_last;

  // multiply stage
  logic                  b_valid;
  logic                  b_last;
  logic [IW-1:0]         b_idx;
  jvsl_pkg::vel_t        b_target;
  logic [VW-1:0]         ram_rdata;
  jvsl_pkg::vel_t        b_prev;
  logic signed [VW:0]    b_diff;
  logic signed [AW:0]    b_alpha;
  logic signed [PW-1:0]  b_prod;
  logic [AW-1:0]         alpha_eff;

  // clamp / write-back stage
  logic                  c_valid;
  logic                  c_last;
  logic [IW-1:0]         c_idx;
  jvsl_pkg::vel_t        c_prev;
  logic signed [PW-1:0]  c_prod;
  logic signed [SW-1:0]  step_raw;
  logic signed [SW-1:0]  step_lim;
  logic signed [SW-1:0]  step_cl;
  logic signed [VW:0]    vsum;
  logic signed [VW:0]    vlim;
  jvsl_pkg::vel_t        nv;

  // result build and output register
  jvsl_pkg::vel_t acc   [J];
  jvsl_pkg::vel_t cmd_q [J];

  // handshake
  logic          accept;
  logic          out_free;
  logic          out_load;
  logic [HW-1:0] eff_count;
  logic          hold_hit;

  assign in_tgt[0] = target_j0;
  assign in_tgt[1] = target_j1;
  assign in_tgt[2] = target_j2;
  assign in_tgt[3] = target_j3;
  assign in_tgt[4] = target_j4;
  assign in_tgt[5] = target_j5;
  assign in_tgt[6] = target_j6;

  assign cmd_j0 = cmd_q[0];
  assign cmd_j1 = cmd_q[1];
  assign cmd_j2 = cmd_q[2];
  assign cmd_j3 = cmd_q[3];
  assign cmd_j4 = cmd_q[4];
  assign cmd_j5 = cmd_q[5];
  assign cmd_j6 = cmd_q[6];

  // the output register parts the two sides: a new word is taken while the
  // finished one moves into it
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == jvsl_pkg::ST_DONE) && out_free;
  assign in_ready = (state == jvsl_pkg::ST_IDLE) || out_load;
  assign accept   = in_valid && in_ready;

  // restart zeroes the counter before the hold decision
  assign eff_count = restart ? '0 : hold_count;
  assign hold_hit  = eff_count < hold_ticks;

  assign rd_en   = (state == jvsl_pkg::ST_RUN);
  assign rd_last = (rd_idx == LAST_IDX);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      jvsl_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = hold_hit ? jvsl_pkg::ST_DONE : jvsl_pkg::ST_RUN;
        end
      end
      jvsl_pkg::ST_RUN: begin
        if (rd_last) begin
          state_next = jvsl_pkg::ST_WAIT;
        end
      end
      jvsl_pkg::ST_WAIT: begin
        // last joint written back at this edge
        if (c_valid && c_last) begin
          state_next = jvsl_pkg::ST_DONE;
        end
      end
      jvsl_pkg::ST_DONE: begin
        if (out_free) begin
          if (accept) begin
            state_next = hold_hit ? jvsl_pkg::ST_DONE : jvsl_pkg::ST_RUN;
          end else begin
            state_next = jvsl_pkg::ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jvsl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha      <= jvsl_pkg::ALPHA_RESET;
      hold_ticks <= jvsl_pkg::HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jvsl_pkg::REG_ALPHA: alpha      <= cfg_data;
        jvsl_pkg::REG_HOLD:  hold_ticks <= cfg_data[HW-1:0];
      endcase
    end
  end

  // hold counter, valid bits and the word type
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count <= '0;
      vbit       <= '0;
      hold_flag  <= 1'b0;
    end else begin
      if (accept) begin
        hold_count <= hold_hit ? eff_count + HW'(1) : eff_count;
        hold_flag  <= hold_hit;
      end
      // a restart clears every stored velocity at once; no write-back is in
      // flight while a word is accepted
      if (accept && restart) begin
        vbit <= '0;
      end else if (c_valid) begin
        vbit[c_idx] <= 1'b1;
      end
    end
  end

  // input buffer and read index
  always_ff @(posedge clk) begin
    if (accept) begin
      tgt    <= in_tgt;
      rd_idx <= '0;
    end else if (rd_en) begin
      rd_idx <= rd_idx + IW'(1);
    end
  end

  // stored velocities, one entry per joint
  jvsl_ram #(
    .WIDTH (VW),
    .DEPTH (J)
  ) u_vel_ram (
    .clk   (clk),
    .we    (c_valid),
    .waddr (c_idx),
    .wdata (nv),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // alpha is clamped into its legal range at use
  always_comb begin
    if (alpha < jvsl_pkg::ALPHA_MIN) begin
      alpha_eff = jvsl_pkg::ALPHA_MIN;
    end else if (alpha > jvsl_pkg::ALPHA_MAX) begin
      alpha_eff = jvsl_pkg::ALPHA_MAX;
    end else begin
      alpha_eff = alpha;
    end
  end

  // multiply stage: ram data arrives here, an unwritten entry reads as zero
  assign b_prev  = vbit[b_idx] ? $signed(ram_rdata) : '0;
  assign b_diff  = (VW + 1)'(b_target) - (VW + 1)'(b_prev);
  assign b_alpha = $signed({1'b0, alpha_eff});
  assign b_prod  = b_diff * b_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      b_valid <= rd_en;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_idx    <= rd_idx;
    b_last   <= rd_last;
    b_target <= tgt[rd_idx];
    c_idx    <= b_idx;
    c_last   <= b_last;
    c_prev   <= b_prev;
    c_prod   <= b_prod;
  end

  // clamp stage: floor shift, slew clamp, add, velocity clamp
  assign step_raw = c_prod[PW-1:16];
  assign step_lim = SW'(jvsl_pkg::step_cap(3'(c_idx)));
  assign vlim     = (VW + 1)'(jvsl_pkg::vel_cap(3'(c_idx)));

  always_comb begin
    if (step_raw > step_lim) begin
      step_cl = step_lim;
    end else if (step_raw < -step_lim) begin
      step_cl = -step_lim;
    end else begin
      step_cl = step_raw;
    end
  end

  assign vsum = (VW + 1)'(c_prev) + (VW + 1)'(step_cl);

  always_comb begin
    if (vsum > vlim) begin
      nv = VW'(vlim);
    end else if (vsum < -vlim) begin
      nv = VW'(-vlim);
    end else begin
      nv = VW'(vsum);
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid) begin
      acc[c_idx] <= nv;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      holding <= hold_flag;
      for (int j = 0; j < J; j++) begin
        cmd_q[j] <= hold_flag ? '0 : acc[j];
      end
    end
  end

endmodule

### src/jvsl_ram.sv
// ----------------------------------------------------------------------------
// jvsl_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module jvsl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/jvsl_checker.sv
// ----------------------------------------------------------------------------
// jvsl_checker
// port-level checks of the joint velocity smoothing limiter
// ----------------------------------------------------------------------------
module jvsl_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [jvsl_pkg::VEL_W-1:0] cmd_j0,
  input logic signed [jvsl_pkg::VEL_W-1:0] cmd_j1,
  input logic signed [jvsl_pkg::VEL_W-1:0] cmd_j2,
  input logic signed [jvsl_pkg::VEL_W-1:0] cmd_j3,
  input logic signed [jvsl_pkg::VEL_W-1:0] cmd_j4,
  input logic signed [jvsl_pkg::VEL_W-1:0] cmd_j5,
  input logic signed [jvsl_pkg::VEL_W-1:0] cmd_j6,
  input logic                              holding
);

  // nothing leaves the block in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  // a hold word carries all zero commands
  a_hold_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && holding) |->
      (cmd_j0 == 0 && cmd_j1 == 0 && cmd_j2 == 0 && cmd_j3 == 0 &&
       cmd_j4 == 0 && cmd_j5 == 0 && cmd_j6 == 0))
    else $error("hold word with nonzero command");

  // commands stay inside the joint velocity limits
  a_vel_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (cmd_j0 <= 16'sd10732 && cmd_j0 >= -16'sd10732 &&
       cmd_j1 <= 16'sd10732 && cmd_j1 >= -16'sd10732 &&
       cmd_j2 <= 16'sd10732 && cmd_j2 >= -16'sd10732 &&
       cmd_j3 <= 16'sd10732 && cmd_j3 >= -16'sd10732 &&
       cmd_j4 <= 16'sd21545 && cmd_j4 >= -16'sd21545 &&
       cmd_j5 <= 16'sd17121 && cmd_j5 >= -16'sd17121 &&
       cmd_j6 <= 16'sd21545 && cmd_j6 >= -16'sd21545))
    else $error("command beyond joint velocity limit");

  // a stalled output word stays valid and keeps holding, cmd_j0 and cmd_j6
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(holding) && $stable(cmd_j0) && $stable(cmd_j6)))
    else $error("stalled output word changed");

endmodule

bind joint_velocity_smoothing_limiter jvsl_checker u_jvsl_checker (.*);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the joint velocity smoothing limiter: drives control
// ticks through the valid/ready input, predicts each commanded velocity word
// and compares it field by field against the output word, under random idling
// and long output back-pressure
// ----------------------------------------------------------------------------
module tb;

  localparam int JOINTS = jvsl_pkg::JOINTS;
  localparam int CFG_W  = jvsl_pkg::ALPHA_W;
  localparam int HLD_W  = jvsl_pkg::HOLD_W;

  typedef jvsl_pkg::vel_t vel_t;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake or register write
  localparam int STALL_LEN      = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 16;    // settle time after the last owed word
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_TICKS    = 200;

  // per-joint limits in q3.12: velocity and acceleration per tick
  localparam int VEL_LIMIT  [JOINTS] = '{10732, 10732, 10732, 10732, 21545, 17121, 21545};
  localparam int STEP_LIMIT [JOINTS] = '{61, 31, 41, 51, 61, 82, 82};

  // one control tick as it enters the block
  typedef struct packed {
    vel_t [JOINTS-1:0] target;
    logic              restart;
  } tick_t;

  // one commanded velocity word as it leaves the block
  typedef struct packed {
    vel_t [JOINTS-1:0] cmd;
    logic              holding;
  } cmd_word_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  // block inputs, all known from time zero
  logic                cfg_we    = 1'b0;
  logic                cfg_index = jvsl_pkg::REG_ALPHA;
  logic [CFG_W-1:0]    cfg_data  = '0;
  logic                in_valid  = 1'b0;
  vel_t                target_j0 = '0;
  vel_t                target_j1 = '0;
  vel_t                target_j2 = '0;
  vel_t                target_j3 = '0;
  vel_t                target_j4 = '0;
  vel_t                target_j5 = '0;
  vel_t                target_j6 = '0;
  logic                restart   = 1'b0;
  logic                out_ready = 1'b0;

  // block outputs
  logic in_ready;
  logic out_valid;
  vel_t cmd_j0, cmd_j1, cmd_j2, cmd_j3, cmd_j4, cmd_j5, cmd_j6;
  logic holding;

  joint_velocity_smoothing_limiter u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .target_j0 (target_j0),
    .target_j1 (target_j1),
    .target_j2 (target_j2),
    .target_j3 (target_j3),
    .target_j4 (target_j4),
    .target_j5 (target_j5),
    .target_j6 (target_j6),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd_j0    (cmd_j0),
    .cmd_j1    (cmd_j1),
    .cmd_j2    (cmd_j2),
    .cmd_j3    (cmd_j3),
    .cmd_j4    (cmd_j4),
    .cmd_j5    (cmd_j5),
    .cmd_j6    (cmd_j6),
    .holding   (holding)
  );

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  // shadow of the block's registers and stored velocities, updated at each
  // accepted tick and each register write
  logic [CFG_W-1:0]   shadow_alpha     = jvsl_pkg::ALPHA_RESET;
  int                 shadow_hold_len  = int'(jvsl_pkg::HOLD_RESET);
  int                 shadow_hold_cnt  = 0;
  int                 shadow_vel [JOINTS] = '{default: 0};

  cmd_word_t cmd_expect_q [$];   // commanded words still owed by the block
  int        fail_count   = 0;
  int        quiet_cycles = 0;

  // idling in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // hold-off request: the receiver notices a change of stall_req
  int stall_req  = 0;
  int stall_ack  = 0;
  int stall_left = 0;

  // ---------------------------------------------------------------------------
  // predictor: ema step with floor shift, slew clamp, velocity clamp, and the
  // startup hold window after restart
  // ---------------------------------------------------------------------------
  function automatic cmd_word_t smooth_tick(input tick_t t);
    cmd_word_t r;
    longint    a;
    longint    diff;
    longint    step;
    longint    nv;
    r = '0;
    // alpha outside [7, 65536] is clamped into range
    a = longint'(shadow_alpha);
    if (a < longint'(jvsl_pkg::ALPHA_MIN)) a = longint'(jvsl_pkg::ALPHA_MIN);
    if (a > longint'(jvsl_pkg::ALPHA_MAX)) a = longint'(jvsl_pkg::ALPHA_MAX);
    // restart clears stored velocities and the hold counter first
    if (t.restart) begin
      for (int j = 0; j < JOINTS; j++) shadow_vel[j] = 0;
      shadow_hold_cnt = 0;
    end
    // inside the hold window: zeros, stored velocities untouched
    if (shadow_hold_cnt < shadow_hold_len) begin
      shadow_hold_cnt++;
      r.holding = 1'b1;
      return r;
    end
    for (int j = 0; j < JOINTS; j++) begin
      diff = longint'($signed(t.target[j])) - longint'(shadow_vel[j]);
      // arithmetic shift floors negative products toward minus infinity
      step = (diff * a) >>> 16;
      if (step > STEP_LIMIT[j]) step = STEP_LIMIT[j];
      if (step < -STEP_LIMIT[j]) step = -STEP_LIMIT[j];
      nv = longint'(shadow_vel[j]) + step;
      if (nv > VEL_LIMIT[j]) nv = VEL_LIMIT[j];
      if (nv < -VEL_LIMIT[j]) nv = -VEL_LIMIT[j];
      shadow_vel[j] = int'(nv);
      r.cmd[j] = vel_t'(nv);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: ready drops at random, or for a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_req != stall_ack) begin
      stall_ack  = stall_req;
      stall_left = STALL_LEN;
    end
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // output check: every accepted word against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_words
    vel_t      got [JOINTS];
    cmd_word_t want;
    if (!rst && out_valid && out_ready) begin
      got[0] = cmd_j0;
      got[1] = cmd_j1;
      got[2] = cmd_j2;
      got[3] = cmd_j3;
      got[4] = cmd_j4;
      got[5] = cmd_j5;
      got[6] = cmd_j6;
      if (cmd_expect_q.size() == 0) begin
        $error("output word with none expected: holding %0b", holding);
        fail_count++;
      end else begin
        want = cmd_expect_q.pop_front();
        for (int j = 0; j < JOINTS; j++) begin
          if (got[j] !== want.cmd[j]) begin
            $error("cmd_j%0d mismatch: expected %0d, actual %0d",
                   j, $signed(want.cmd[j]), $signed(got[j]));
            fail_count++;
          end
        end
        if (holding !== want.holding) begin
          $error("holding mismatch: expected %0b, actual %0b", want.holding, holding);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any handshake or register write ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no handshake for %0d cycles, %0d words outstanding",
             quiet_cycles, cmd_expect_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // shared tasks, all entered and left at a falling edge
  // ---------------------------------------------------------------------------
  // offer one tick, wait for it to be taken, then record what it must produce
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    target_j0 = t.target[0];
    target_j1 = t.target[1];
    target_j2 = t.target[2];
    target_j3 = t.target[3];
    target_j4 = t.target[4];
    target_j5 = t.target[5];
    target_j6 = t.target[6];
    restart   = t.restart;
    do @(posedge clk); while (!in_ready);
    cmd_expect_q.insert(cmd_expect_q.size(), smooth_tick(t));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // wait until every owed word has come back and the pipeline has settled
  task automatic wait_idle();
    while (cmd_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write, only called while the block is idle
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == jvsl_pkg::REG_ALPHA)
      shadow_alpha = data;
    else
      shadow_hold_len = int'(data[HLD_W-1:0]);
  endtask

  // the same target on every joint
  function automatic tick_t flat_tick(input int value, input logic rs);
    tick_t t;
    for (int j = 0; j < JOINTS; j++) t.target[j] = vel_t'(value);
    t.restart = rs;
    return t;
  endfunction

  // random target for one joint: mostly within the joint's range widened by
  // 300, some full range, some corner values
  function automatic vel_t pick_target(input int j);
    int lim;
    lim = VEL_LIMIT[j] + 300;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       return vel_t'(-32768);
          1:       return vel_t'(32767);
          2:       return vel_t'(VEL_LIMIT[j]);
          3:       return vel_t'(-VEL_LIMIT[j]);
          default: return '0;
        endcase
      end
      1, 2, 3: return vel_t'($urandom);
      default: return vel_t'(int'($urandom_range(2 * lim)) - lim);
    endcase
  endfunction

  function automatic tick_t random_tick(input int restart_pct);
    tick_t t;
    for (int j = 0; j < JOINTS; j++) t.target[j] = pick_target(j);
    t.restart = ($urandom_range(99) < restart_pct);
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset values: long hold, so every word is a zero hold word; then a hold
  // length below the count already reached, so the hold ends at once
  task automatic test_startup_hold();
    send_tick(flat_tick(32767, 1'b0));
    send_tick(flat_tick(-32768, 1'b0));
    send_tick(flat_tick(1234, 1'b0));
    wait_idle();
    write_reg(jvsl_pkg::REG_ALPHA, jvsl_pkg::ALPHA_MAX);
    write_reg(jvsl_pkg::REG_HOLD, CFG_W'(2));
    send_tick(flat_tick(32767, 1'b0));
    send_tick(flat_tick(-32768, 1'b0));
  endtask

  // extremes of the target fields, with a zero-length hold after restart
  task automatic test_field_extremes();
    tick_t t;
    wait_idle();
    write_reg(jvsl_pkg::REG_HOLD, '0);
    send_tick(flat_tick(32767, 1'b1));
    send_tick(flat_tick(-32768, 1'b0));
    for (int j = 0; j < JOINTS; j++) t.target[j] = (j % 2) ? vel_t'(-32768) : vel_t'(32767);
    t.restart = 1'b0;
    send_tick(t);
    send_tick(flat_tick(0, 1'b0));
    for (int j = 0; j < JOINTS; j++)
      t.target[j] = (j % 2) ? vel_t'(-VEL_LIMIT[j]) : vel_t'(VEL_LIMIT[j]);
    send_tick(t);
  endtask

  // alpha below the minimum, above the maximum, and floor of negative steps
  task automatic test_alpha_clamp();
    wait_idle();
    write_reg(jvsl_pkg::REG_ALPHA, '0);
    send_tick(flat_tick(-1, 1'b1));     // tiny negative step floors to -1
    send_tick(flat_tick(1, 1'b0));
    wait_idle();
    write_reg(jvsl_pkg::REG_ALPHA, CFG_W'(6));
    send_tick(flat_tick(-32768, 1'b0));
    wait_idle();
    write_reg(jvsl_pkg::REG_ALPHA, CFG_W'(65537));
    send_tick(flat_tick(32767, 1'b0));
    wait_idle();
    write_reg(jvsl_pkg::REG_ALPHA, '1);
    send_tick(random_tick(0));
    wait_idle();
    write_reg(jvsl_pkg::REG_ALPHA, jvsl_pkg::ALPHA_MIN);
    send_tick(flat_tick(-5, 1'b0));
  endtask

  // longest hold, then the hold length lowered under the running count, then
  // a one-tick hold after restart
  task automatic test_hold_window();
    wait_idle();
    write_reg(jvsl_pkg::REG_ALPHA, CFG_W'(20000));
    write_reg(jvsl_pkg::REG_HOLD, CFG_W'(4095));
    send_tick(flat_tick(5000, 1'b1));
    send_tick(random_tick(0));
    send_tick(random_tick(0));
    wait_idle();
    write_reg(jvsl_pkg::REG_HOLD, CFG_W'(1));
    send_tick(flat_tick(-7000, 1'b0));
    send_tick(flat_tick(7000, 1'b1));
    send_tick(flat_tick(7000, 1'b0));
  endtask

  // receiver holds off while the sender keeps offering, so the block fills
  // and drops in_ready
  task automatic test_backpressure();
    int keep_send;
    int keep_recv;
    keep_send = send_idle_pct;
    keep_recv = recv_idle_pct;
    wait_idle();
    write_reg(jvsl_pkg::REG_ALPHA, CFG_W'($urandom_range(1000, 40000)));
    write_reg(jvsl_pkg::REG_HOLD, CFG_W'(2));
    send_idle_pct = 0;
    stall_req++;
    for (int i = 0; i < 24; i++) send_tick(random_tick(5));
    wait_idle();
    send_idle_pct = keep_send;
    recv_idle_pct = keep_recv;
  endtask

  // random ticks over several register settings and idling patterns
  task automatic test_random_ticks();
    logic [CFG_W-1:0] a;
    int               h;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      // sender 25 / receiver 52, then swapped, then no idling
      case (p / 2)
        0:       begin send_idle_pct = 25; recv_idle_pct = 52; end
        1:       begin send_idle_pct = 52; recv_idle_pct = 25; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      case (p)
        0:       begin a = CFG_W'($urandom_range(200, 3000));     h = $urandom_range(3); end
        1:       begin a = jvsl_pkg::ALPHA_MAX;                  h = 0; end
        2:       begin a = CFG_W'($urandom_range(6));             h = $urandom_range(1, 6); end
        3:       begin a = CFG_W'($urandom_range(65537, 131071)); h = 2; end
        4:       begin a = CFG_W'($urandom);                      h = $urandom_range(10); end
        default: begin a = CFG_W'($urandom_range(3000, 20000));   h = 1; end
      endcase
      write_reg(jvsl_pkg::REG_ALPHA, a);
      // upper data bits beyond the hold field are don't-care
      write_reg(jvsl_pkg::REG_HOLD, {CFG_W'($urandom) & ~CFG_W'(12'hFFF)} | CFG_W'(h));
      for (int i = 0; i < PHASE_TICKS; i++) begin
        send_tick(random_tick(3));
        // now and then the sender waits for every word to come back
        if ($urandom_range(99) == 0) wait_idle();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 52;
    test_startup_hold();
    test_field_extremes();
    test_alpha_clamp();
    test_hold_window();
    test_backpressure();
    test_random_ticks();
    wait_idle();
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
src/jvsl_pkg.sv
src/jvsl_ram.sv
src/joint_velocity_smoothing_limiter.sv
src/jvsl_checker.sv
tb/sv/tb.sv
